[rtl/core/pfi_pkg.sv]
package pfi_pkg;

    // Coordinate width of one point
    localparam int COORD_W = 20;
    // Width of the reported frontier size
    localparam int SIZE_W  = 7;
    localparam int TOTAL_W = 32;

    typedef struct packed {
        logic               new_set;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic [SIZE_W-1:0]  frontier_size;
        logic [TOTAL_W-1:0] running_total;
        logic               kept;
        logic               overflow;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_pfi_cmd;

endpackage

[rtl/core/pareto_frontier_insert_unit.sv]
// Pareto frontier insert unit. Each input transfer carries a point and a
// new_set flag; one result transfer follows with the frontier size, the
// saturating running total and the kept/overflow flags. Each item passes the
// parallel compare cells over all table entries, then the shift/compact of the
// register table, held while the last result is stalled. Results sit in an
// output register, so the next item is taken while the last result waits.
// No clearing pass after reset: the table is tracked by its fill count.
module pareto_frontier_insert_unit import pfi_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_pfi_cmd cmd;
    logic [$clog2(CAPACITY+1)-1:0] count;

    pfi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    pfi_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in_data),
        .o_item  (o_out_data),
        .o_count (count)
    );

    // Table never grows past capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= ($clog2(CAPACITY+1))'(CAPACITY))
        else $error("frontier count above capacity");

    // A point is never both kept and dropped for overflow
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.kept && o_out_data.overflow))
        else $error("kept and overflow both set");

    // Accepted item blocks input on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

endmodule

[rtl/core/pfi_datapath.sv]
module pfi_datapath import pfi_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pfi_cmd  i_cmd,
    input  t_in_item  i_item,
    output t_out_item o_item,
    output logic [$clog2(CAPACITY+1)-1:0] o_count
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int EW  = 2 * COORD_W;
    localparam int FW  = CAPACITY * EW;
    localparam int SHW = $clog2(FW + 1);

    // Frontier table, one row of cells, entry = {x, y}
    logic [EW-1:0] r_ent [CAPACITY];
    logic [CW-1:0] r_cnt;
    logic [TOTAL_W-1:0] r_total;

    // Compare results held for the update cycle
    logic [COORD_W-1:0] r_px, r_py;
    logic [CW-1:0]      r_ecnt, r_rem, r_low;
    logic               r_clr, r_chg, r_ins, r_ovf;
    t_out_item          r_out;

    // Compare stage signals
    logic [CW-1:0]       ecnt, at_idx, low_idx;
    logic [CAPACITY-1:0] lt, rm, kl, vld;
    logic                dom, same, ovf;
    logic [COORD_W-1:0]  ex, ey;

    // Parallel compare cells against the incoming point
    always_comb begin
        ecnt    = i_item.new_set ? '0 : r_cnt;
        at_idx  = '0;
        low_idx = '0;
        dom     = 1'b0;
        same    = 1'b0;
        ex      = '0;
        ey      = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            ex     = r_ent[i][EW-1:COORD_W];
            ey     = r_ent[i][COORD_W-1:0];
            vld[i] = CW'(i) < ecnt;
            lt[i]  = vld[i] && (ex < i_item.point_x);
            rm[i]  = lt[i] && (ey <= i_item.point_y);
            kl[i]  = lt[i] && !rm[i];
        end
        // lt and kl are prefix masks; their edges give at and low
        for (int i = 0; i <= CAPACITY; i++) begin
            if (((i == 0) || lt[(i == 0) ? 0 : i-1]) && ((i == CAPACITY) || !lt[(i == CAPACITY) ? 0 : i]))
                at_idx = at_idx | CW'(i);
            if (((i == 0) || kl[(i == 0) ? 0 : i-1]) && ((i == CAPACITY) || !kl[(i == CAPACITY) ? 0 : i]))
                low_idx = low_idx | CW'(i);
        end
        // Entry at the insertion point decides dominance and same x
        for (int i = 0; i < CAPACITY; i++) begin
            if (vld[i] && !lt[i] && ((i == 0) || lt[(i == 0) ? 0 : i-1])) begin
                dom  = dom  | (r_ent[i][COORD_W-1:0] >= i_item.point_y);
                same = same | (r_ent[i][EW-1:COORD_W] == i_item.point_x);
            end
        end
        ovf = !dom && !same && (at_idx == low_idx) && (ecnt == CW'(CAPACITY));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px   <= i_item.point_x;
            r_py   <= i_item.point_y;
            r_ecnt <= ecnt;
            r_rem  <= at_idx - low_idx;
            r_low  <= low_idx;
            r_clr  <= i_item.new_set;
            r_chg  <= !dom && !ovf;
            r_ins  <= !dom && !ovf && !same;
            r_ovf  <= ovf;
        end
    end

    // Compaction: tail shifts down by removed count, up one on insert
    logic [FW-1:0]      flat, sh;
    logic [SHW-1:0]     shamt;
    logic [EW-1:0]      n_ent [CAPACITY];
    logic [CW-1:0]      n_cnt;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] base;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++)
            flat[i*EW +: EW] = r_ent[i];
        shamt = SHW'(r_rem) * SHW'(EW);
        sh    = flat >> shamt;
        if (r_ins)
            sh = sh << EW;
        for (int j = 0; j < CAPACITY; j++) begin
            if (!r_chg || (CW'(j) < r_low))
                n_ent[j] = r_ent[j];
            else if (r_ins && (CW'(j) == r_low))
                n_ent[j] = {r_px, r_py};
            else
                n_ent[j] = sh[j*EW +: EW];
        end
        n_cnt = r_chg ? (r_ecnt - r_rem + CW'(r_ins)) : r_ecnt;
        base  = r_clr ? '0 : r_total;
        sum   = {1'b0, base} + (TOTAL_W+1)'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int j = 0; j < CAPACITY; j++)
                r_ent[j] <= n_ent[j];
            r_out.frontier_size <= SIZE_W'(n_cnt);
            r_out.running_total <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            r_out.kept          <= r_ins;
            r_out.overflow      <= r_ovf;
        end
    end

    // Count and total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_total <= '0;
        end else if (i_cmd.commit) begin
            r_cnt   <= n_cnt;
            r_total <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        end
    end

    assign o_item  = r_out;
    assign o_count = r_cnt;

endmodule

[rtl/core/pfi_ctrl.sv]
module pfi_ctrl import pfi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_pfi_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
